// ===== rtl/bda_pkg.sv =====
// Package for the packed-BCD arithmetic unit: sizes, request and error codes,
// the pipeline payload struct and the digit helper functions.
// No dependencies.
package bda_pkg;

    localparam int DIGITS = 16;
    localparam int BCD_W  = 64;
    localparam int BIN_W  = 64;
    localparam int CNT_W  = 5;
    localparam int NSTAGE = 8;
    localparam int DPS    = (DIGITS + NSTAGE - 1) / NSTAGE;
    localparam int PADD   = NSTAGE * DPS;
    localparam int DW     = DIGITS * 4;
    localparam int PW     = PADD * 4;
    localparam int BPS    = BIN_W / NSTAGE;

    typedef logic [BCD_W-1:0] word_t;
    typedef logic [DW-1:0]    dig_t;
    typedef logic [PW-1:0]    pad_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        REQ_ADD,
        REQ_SUB,
        REQ_CMP,
        REQ_CONV
    } req_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_OVERFLOW,
        ERR_UNDERFLOW
    } err_t;

    typedef struct packed {
        req_t              op;
        err_t              err;
        logic              eq;
        logic              lt;
        pad_t              a_rem;
        pad_t              b_rem;
        pad_t              sum;
        logic              carry;
        logic [BIN_W-1:0]  bin_rem;
        dig_t              dab;
    } pipe_t;

    typedef struct packed {
        word_t result_bcd;
        cnt_t  result_digits;
        logic  is_equal;
        logic  is_less;
        err_t  error_code;
    } rsp_t;

    // nibbles above 9 read as 9, nibbles above the digit range dropped
    function automatic dig_t clamp_bcd(input word_t x);
        dig_t       r;
        logic [3:0] n;
        for (int i = 0; i < DIGITS; i++)
        begin
            n = x[4*i +: 4];
            r[4*i +: 4] = (n > 4'd9) ? 4'd9 : n;
        end
        return r;
    endfunction

    function automatic cnt_t sig_len(input dig_t d);
        cnt_t len;
        len = cnt_t'(1);
        for (int i = 0; i < DIGITS; i++)
        begin
            if (d[4*i +: 4] != 4'd0)
                len = cnt_t'(i + 1);
        end
        return len;
    endfunction

    // one double-dabble step; carries out of the top digit are dropped,
    // which keeps the value modulo 10**DIGITS
    function automatic dig_t dabble_step(input dig_t d, input logic b);
        dig_t       t;
        logic [3:0] n;
        for (int i = 0; i < DIGITS; i++)
        begin
            n = d[4*i +: 4];
            t[4*i +: 4] = (n >= 4'd5) ? n + 4'd3 : n;
        end
        return {t[DW-2:0], b};
    endfunction

endpackage

// ===== rtl/bda_req_if.sv =====
// Request channel of the BCD unit: valid/ready handshake plus request payload.
// Depends on bda_pkg.
interface bda_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [bda_pkg::BCD_W-1:0] operand_a;
    logic [bda_pkg::BCD_W-1:0] operand_b;
    logic [bda_pkg::BIN_W-1:0] binary_value;

    modport source (output valid, req_type, operand_a, operand_b, binary_value,
                    input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, binary_value,
                    output ready);
endinterface

// ===== rtl/bda_rsp_if.sv =====
// Result channel of the BCD unit: valid/ready handshake plus result payload.
// Depends on bda_pkg.
interface bda_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [bda_pkg::BCD_W-1:0] result_bcd;
    logic [bda_pkg::CNT_W-1:0] result_digits;
    logic                      is_equal;
    logic                      is_less;
    logic [1:0]                error_code;

    modport source (output valid, result_bcd, result_digits, is_equal, is_less,
                    error_code, input ready);
    modport sink   (input valid, result_bcd, result_digits, is_equal, is_less,
                    error_code, output ready);
endinterface

// ===== rtl/bcd_decimal_arith_unit_top.sv =====
// Packed-BCD add / subtract / compare / binary-to-BCD unit.
// Pipeline: a request passes through ten registers (prep stage, NSTAGE = 8
// add/dabble stages, output stage) before its result is valid.
// Throughput: one request per cycle; each stage holds under backpressure.
// Reset: rst_n clears all stage valid bits asynchronously; no other state.
module bcd_decimal_arith_unit_top
(
    input  logic      clk,
    input  logic      rst_n,
    bda_req_if.sink   req,
    bda_rsp_if.source rsp
);
    import bda_pkg::*;

    logic [NSTAGE:0] stg_valid;
    logic [NSTAGE:0] stg_ready;
    pipe_t           stg_data [NSTAGE+1];

    bda_prep u_prep
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .valid (stg_valid[0]),
        .data  (stg_data[0]),
        .ready (stg_ready[0])
    );

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_step
        bda_step u_step
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (stg_valid[g]),
            .in_data  (stg_data[g]),
            .in_ready (stg_ready[g]),
            .valid    (stg_valid[g+1]),
            .data     (stg_data[g+1]),
            .ready    (stg_ready[g+1])
        );
    end

    bda_finish u_finish
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[NSTAGE]),
        .in_data  (stg_data[NSTAGE]),
        .in_ready (stg_ready[NSTAGE]),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/bda_prep.sv =====
// First pipeline stage: digit clamp, compare, error checks, payload setup.
// Depends on bda_pkg and bda_req_if.
module bda_prep
(
    input  logic           clk,
    input  logic           rst_n,
    bda_req_if.sink        req,
    output logic           valid,
    output bda_pkg::pipe_t data,
    input  logic           ready
);
    import bda_pkg::*;

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;
    dig_t  a_dig;
    dig_t  b_dig;
    logic  a_lt_b;
    req_t  op;

    assign req.ready = !valid_reg || ready;
    assign valid     = valid_reg;
    assign data      = data_reg;

    always_comb
    begin
        a_dig  = clamp_bcd(req.operand_a);
        b_dig  = clamp_bcd(req.operand_b);
        // packed BCD orders the same as the digit strings
        a_lt_b = a_dig < b_dig;
        op     = req_t'(req.req_type);

        data_next.op = op;
        case (op)
            REQ_ADD:
            begin
                data_next.err = (a_dig[DW-1 -: 4] != 4'd0 || b_dig[DW-1 -: 4] != 4'd0)
                                ? ERR_OVERFLOW : ERR_NONE;
            end
            REQ_SUB:
            begin
                data_next.err = a_lt_b ? ERR_UNDERFLOW : ERR_NONE;
            end
            default:
            begin
                data_next.err = ERR_NONE;
            end
        endcase
        data_next.eq      = (op == REQ_CMP) && (a_dig == b_dig);
        data_next.lt      = (op == REQ_CMP) && a_lt_b;
        data_next.a_rem   = pad_t'(a_dig);
        data_next.b_rem   = pad_t'(b_dig);
        data_next.sum     = '0;
        data_next.carry   = 1'b0;
        data_next.bin_rem = req.binary_value;
        data_next.dab     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req.ready)
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/bda_step.sv =====
// Middle pipeline stage: a slice of decimal add/subtract digits and a slice
// of double-dabble steps for the binary conversion. Depends on bda_pkg.
module bda_step
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  bda_pkg::pipe_t in_data,
    output logic           in_ready,
    output logic           valid,
    output bda_pkg::pipe_t data,
    input  logic           ready
);
    import bda_pkg::*;

    logic       valid_reg;
    pipe_t      data_reg;
    pipe_t      data_next;
    logic [4:0] da;
    logic [4:0] db;
    logic [4:0] s;
    logic [3:0] dig;

    assign in_ready = !valid_reg || ready;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_comb
    begin
        data_next = in_data;
        da  = '0;
        db  = '0;
        s   = '0;
        dig = '0;
        // lowest remaining digits; results enter from the top of sum
        for (int k = 0; k < DPS; k++)
        begin
            da = {1'b0, data_next.a_rem[3:0]};
            db = {1'b0, data_next.b_rem[3:0]};
            if (data_next.op == REQ_SUB)
            begin
                s = da - db - 5'(data_next.carry);
                if (da < db + 5'(data_next.carry))
                begin
                    dig = s[3:0] + 4'd10;
                    data_next.carry = 1'b1;
                end
                else
                begin
                    dig = s[3:0];
                    data_next.carry = 1'b0;
                end
            end
            else
            begin
                s = da + db + 5'(data_next.carry);
                if (s >= 5'd10)
                begin
                    dig = 4'(s - 5'd10);
                    data_next.carry = 1'b1;
                end
                else
                begin
                    dig = s[3:0];
                    data_next.carry = 1'b0;
                end
            end
            data_next.sum   = {dig, data_next.sum[PW-1:4]};
            data_next.a_rem = data_next.a_rem >> 4;
            data_next.b_rem = data_next.b_rem >> 4;
        end
        for (int j = 0; j < BPS; j++)
        begin
            data_next.dab     = dabble_step(data_next.dab, data_next.bin_rem[BIN_W-1]);
            data_next.bin_rem = data_next.bin_rem << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ===== rtl/bda_finish.sv =====
// Last pipeline stage: result select, zeroing on error or compare, digit
// count and the output register. Depends on bda_pkg and bda_rsp_if.
module bda_finish
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  bda_pkg::pipe_t in_data,
    output logic           in_ready,
    bda_rsp_if.source      rsp
);
    import bda_pkg::*;

    logic  valid_reg;
    rsp_t  out_reg;
    rsp_t  out_next;
    dig_t  res;

    assign in_ready = !valid_reg || rsp.ready;

    assign rsp.valid         = valid_reg;
    assign rsp.result_bcd    = out_reg.result_bcd;
    assign rsp.result_digits = out_reg.result_digits;
    assign rsp.is_equal      = out_reg.is_equal;
    assign rsp.is_less       = out_reg.is_less;
    assign rsp.error_code    = out_reg.error_code;

    always_comb
    begin
        if (in_data.op == REQ_CONV)
            res = in_data.dab;
        else
            res = in_data.sum[DW-1:0];
        if (in_data.err != ERR_NONE || in_data.op == REQ_CMP)
            res = '0;
        out_next.result_bcd    = word_t'(res);
        out_next.result_digits = sig_len(res);
        out_next.is_equal      = in_data.eq;
        out_next.is_less       = in_data.lt;
        out_next.error_code    = in_data.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            out_reg <= out_next;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench for the packed-BCD add / subtract / compare / convert unit.
// Random and directed requests are scored against an in-bench digit model.
// Depends on bda_pkg, bda_req_if, bda_rsp_if and bcd_decimal_arith_unit_top.
module tb;
    import bda_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [3:0] digit_vec_t [DIGITS];

    int   cycle_count;

    class bcd_scoreboard;
        rsp_t expected_q[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        static function int sig_digits(digit_vec_t d);
            int len;
            len = 1;
            for (int i = 0; i < DIGITS; i++)
            begin
                if (d[i] != 4'd0)
                    len = i + 1;
            end
            return len;
        endfunction

        // -1 when a < b, 0 when equal, 1 when a > b
        static function int order_of(digit_vec_t a, digit_vec_t b);
            for (int i = DIGITS - 1; i >= 0; i--)
            begin
                if (a[i] != b[i])
                    return (a[i] < b[i]) ? -1 : 1;
            end
            return 0;
        endfunction

        static function rsp_t predict_bcd(req_t op, word_t a, word_t b, word_t bin);
            digit_vec_t  da;
            digit_vec_t  db;
            digit_vec_t  dr;
            int          s;
            int          carry;
            int          borrow;
            int          rel;
            logic [63:0] v;
            rsp_t        r;
            r = '0;
            r.error_code = ERR_NONE;
            carry  = 0;
            borrow = 0;
            for (int i = 0; i < DIGITS; i++)
            begin
                da[i] = (a[4*i +: 4] > 4'd9) ? 4'd9 : a[4*i +: 4];
                db[i] = (b[4*i +: 4] > 4'd9) ? 4'd9 : b[4*i +: 4];
                dr[i] = 4'd0;
            end
            rel = order_of(da, db);
            case (op)
                REQ_ADD:
                begin
                    // overflow is flagged on operand length alone
                    if (sig_digits(da) >= DIGITS || sig_digits(db) >= DIGITS)
                        r.error_code = ERR_OVERFLOW;
                    else
                    begin
                        for (int i = 0; i < DIGITS; i++)
                        begin
                            s     = da[i] + db[i] + carry;
                            dr[i] = 4'(s % 10);
                            carry = s / 10;
                        end
                    end
                end
                REQ_SUB:
                begin
                    if (rel < 0)
                        r.error_code = ERR_UNDERFLOW;
                    else
                    begin
                        for (int i = 0; i < DIGITS; i++)
                        begin
                            s = da[i] - db[i] - borrow;
                            borrow = (s < 0) ? 1 : 0;
                            dr[i] = 4'(s + 10 * borrow);
                        end
                    end
                end
                REQ_CMP:
                begin
                    r.is_equal = (rel == 0);
                    r.is_less  = (rel < 0);
                end
                REQ_CONV:
                begin
                    v = bin;
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        dr[i] = 4'(v % 64'd10);
                        v     = v / 64'd10;
                    end
                end
            endcase
            // errors and compares leave dr at zero
            for (int i = 0; i < DIGITS; i++)
                r.result_bcd[4*i +: 4] = dr[i];
            r.result_digits = cnt_t'(sig_digits(dr));
            return r;
        endfunction

        task report(string msg);
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
            errors++;
        endtask

        function void note_request(req_t op, word_t a, word_t b, word_t bin);
            expected_q.push_back(predict_bcd(op, a, b, bin));
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
                report("result with no request pending");
            else
            begin
                want = expected_q.pop_front();
                if (got.result_bcd !== want.result_bcd)
                    report($sformatf("result_bcd got %h want %h",
                                     got.result_bcd, want.result_bcd));
                if (got.result_digits !== want.result_digits)
                    report($sformatf("result_digits got %0d want %0d",
                                     got.result_digits, want.result_digits));
                if (got.is_equal !== want.is_equal)
                    report($sformatf("is_equal got %b want %b",
                                     got.is_equal, want.is_equal));
                if (got.is_less !== want.is_less)
                    report($sformatf("is_less got %b want %b",
                                     got.is_less, want.is_less));
                if (got.error_code !== want.error_code)
                    report($sformatf("error_code got %0d want %0d",
                                     got.error_code, want.error_code));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   sent_count;

    bda_req_if req_ch ();
    bda_rsp_if rsp_ch ();

    bcd_scoreboard sb;

    bcd_decimal_arith_unit_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // mostly no gap, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic word_t make_bcd(int ndig);
        word_t w;
        w = '0;
        for (int i = 0; i < ndig; i++)
            w[4*i +: 4] = 4'($urandom_range(0, 9));
        return w;
    endfunction

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    task send_request(req_t op, word_t a, word_t b, word_t bin);
        int gap;
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= op;
        req_ch.operand_a    <= a;
        req_ch.operand_b    <= b;
        req_ch.binary_value <= bin;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, a, b, bin);
        sent_count++;
        // quiet stretches with back-to-back requests
        gap = ((sent_count % 200) < 50) ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task send_random_request();
        req_t  op;
        word_t a;
        word_t b;
        word_t t;
        int    kind;
        op   = req_t'($urandom_range(0, 3));
        kind = $urandom_range(0, 99);
        a    = make_bcd($urandom_range(0, DIGITS - 1));
        b    = make_bcd($urandom_range(0, DIGITS - 1));
        if (kind < 10)
        begin
            // noise: raw bits, invalid nibbles
            a = rand_word();
            b = rand_word();
        end
        else
        begin
            case (op)
                REQ_ADD:
                begin
                    if (kind < 20)
                        a = make_bcd(DIGITS);
                    else if (kind < 25)
                        b = make_bcd(DIGITS);
                end
                REQ_SUB:
                begin
                    if (kind < 40)
                        a = make_bcd(DIGITS);
                    // valid BCD orders like binary
                    if (kind < 80 && a < b)
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
                REQ_CMP:
                begin
                    if (kind < 40)
                        b = a;
                    else if (kind < 60)
                    begin
                        b = a;
                        b[4*$urandom_range(0, DIGITS - 1) +: 4] = 4'($urandom_range(0, 9));
                    end
                end
                default:
                begin
                end
            endcase
        end
        send_request(op, a, b, rand_word() >> $urandom_range(0, 63));
    endtask

    // result side: random stalls, with quiet stretches, checks every result
    initial
    begin
        int   stall_left;
        rsp_t got;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.result_bcd    = rsp_ch.result_bcd;
                got.result_digits = rsp_ch.result_digits;
                got.is_equal      = rsp_ch.is_equal;
                got.is_less       = rsp_ch.is_less;
                got.error_code    = err_t'(rsp_ch.error_code);
                sb.check_result(got);
            end
            if ((cycle_count % 400) < 100)
                rsp_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        sb                  = new();
        sent_count          = 0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ADD;
        req_ch.operand_a    = '0;
        req_ch.operand_b    = '0;
        req_ch.binary_value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_ADD, 64'h0, 64'h0, 64'h0);
        send_request(REQ_ADD, 64'h0999_9999_9999_9999, 64'h0999_9999_9999_9999, 64'h0);
        send_request(REQ_ADD, 64'h0999_9999_9999_9999, 64'h1, 64'h0);
        // full-length operand overflows even when the sum fits
        send_request(REQ_ADD, 64'h1000_0000_0000_0000, 64'h0, 64'h0);
        send_request(REQ_ADD, 64'h0, 64'h9999_9999_9999_9999, 64'h0);
        send_request(REQ_ADD, 64'h0000_0000_0000_00AF, 64'h1, 64'h0);
        send_request(REQ_ADD, 64'h0FFF_FFFF_FFFF_FFFF, 64'h1, 64'h0);
        send_request(REQ_SUB, 64'h1234, 64'h1234, 64'h0);
        send_request(REQ_SUB, 64'h1, 64'h2, 64'h0);
        send_request(REQ_SUB, 64'h1000_0000_0000_0000, 64'h1, 64'h0);
        send_request(REQ_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0);
        send_request(REQ_SUB, 64'h9999_9999_9999_9999, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_request(REQ_CMP, 64'h42, 64'h42, 64'h0);
        send_request(REQ_CMP, 64'h41, 64'h42, 64'h0);
        send_request(REQ_CMP, 64'h1000_0000_0000_0000, 64'h0999_9999_9999_9999, 64'h0);
        send_request(REQ_CMP, 64'hA, 64'h9, 64'h0);
        send_request(REQ_CMP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h9999_9999_9999_9999, 64'h0);
        send_request(REQ_CONV, 64'h0, 64'h0, 64'd0);
        send_request(REQ_CONV, 64'h0, 64'h0, 64'd1);
        send_request(REQ_CONV, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        // conversion keeps only the low digits
        send_request(REQ_CONV, 64'h0, 64'h0, 64'd10000000000000000);
        send_request(REQ_CONV, 64'h0, 64'h0, 64'd9999999999999999);
        send_request(REQ_CONV, 64'h0, 64'h0, 64'd1234567890123456789);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_random_request();
        req_ch.valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
